// ===== design/ntg_pkg.sv =====
// package: shared types and constants for the nearest target go-to-goal block
`default_nettype none
package ntg_pkg;
  localparam int MaxTargets = 16;
  localparam int IdxW = 4;
  localparam int CordicSteps = 24;
  localparam int AngW = 34;
  localparam logic signed [AngW-1:0] PiQ30 = 34'sd3373259426;
  localparam logic signed [15:0] PiQ = 16'sd12868;

  localparam logic [1:0] REQ_POSE = 2'd0;
  localparam logic [1:0] REQ_ENTRY = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [1:0] CFG_GLIN = 2'd0;
  localparam logic [1:0] CFG_GANG = 2'd1;
  localparam logic [1:0] CFG_COLL = 2'd2;
  localparam logic [1:0] CFG_SRCH = 2'd3;

  typedef struct packed {
    logic scan_clear;
    logic scan_step;
    logic eat_clear;
    logic eat_step;
    logic tick_load;
    logic calc_step;
    logic finish;
  } ntg_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic eat_hit;
    logic calc_done;
    logic drive;
    logic collide;
  } ntg_sts_t;

  function automatic logic signed [AngW-1:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 34'sd843314857;
      5'd1: atan_q30 = 34'sd497837829;
      5'd2: atan_q30 = 34'sd263043837;
      5'd3: atan_q30 = 34'sd133525159;
      5'd4: atan_q30 = 34'sd67021687;
      5'd5: atan_q30 = 34'sd33543516;
      5'd6: atan_q30 = 34'sd16775851;
      5'd7: atan_q30 = 34'sd8388437;
      5'd8: atan_q30 = 34'sd4194283;
      5'd9: atan_q30 = 34'sd2097149;
      default: atan_q30 = (i <= 5'd23) ? (34'sd1 <<< (5'd30 - i)) : 34'sd0;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== design/ntg_ctrl.sv =====
// controller: sequencing of roster scan, eat search and tick calculation
`default_nettype none
module ntg_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            go_scan,
  input  wire logic            go_tick,
  input  wire ntg_pkg::ntg_sts_t sts,
  output ntg_pkg::ntg_cmd_t    cmd,
  output logic                 busy
);
  import ntg_pkg::*;
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_CALC = 5'b00100,
    S_EAT = 5'b01000, S_DONE = 5'b10000
  } state_t;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (go_scan) begin
          cmd.scan_clear = 1'b1;
          state_nxt = S_SCAN;
        end else if (go_tick) begin
          cmd.tick_load = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_IDLE;
      end
      S_CALC: begin
        if (sts.collide) begin
          cmd.eat_clear = 1'b1;
          state_nxt = S_EAT;
        end else if (!sts.drive) begin
          state_nxt = S_DONE;
        end else begin
          cmd.calc_step = 1'b1;
          if (sts.calc_done) state_nxt = S_DONE;
        end
      end
      S_EAT: begin
        cmd.eat_step = 1'b1;
        if (sts.eat_hit || sts.scan_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

  a_start_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_clear || cmd.tick_load) |-> state_r == S_IDLE) else $error("start not idle");
  a_finish_returns: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == S_IDLE) else $error("finish not to idle");
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not onehot");
endmodule
`default_nettype wire

// ===== design/ntg_dp.sv =====
// datapath: pose, goal, roster, distance, cordic and sqrt units
`default_nettype none
module ntg_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire logic [1:0]        in_req_type,
  input  wire logic [15:0]       in_pose_x,
  input  wire logic [15:0]       in_pose_y,
  input  wire logic signed [14:0] in_pose_theta,
  input  wire logic [3:0]        in_entry_index,
  input  wire logic [15:0]       in_entry_x,
  input  wire logic [15:0]       in_entry_y,
  input  wire logic [7:0]        in_entry_id,
  input  wire logic [4:0]        in_list_length,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [16:0]       cfg_wdata,
  input  wire ntg_pkg::ntg_cmd_t cmd,
  output ntg_pkg::ntg_sts_t      sts,
  output logic                   go_scan,
  output logic                   go_tick,
  output logic                   out_valid,
  output logic [19:0]            out_linear_speed,
  output logic signed [18:0]     out_angular_rate,
  output logic                   out_eaten,
  output logic [7:0]             out_eaten_id
);
  import ntg_pkg::*;

  logic [3:0] glin_r, gang_r;
  logic [16:0] coll_r, srch_r;
  logic [15:0] cx_r, cy_r, gx_r, gy_r;
  logic signed [14:0] th_r;
  logic known_r, has_r;
  logic [7:0] gid_r;
  logic [15:0] rx_r [MaxTargets];
  logic [15:0] ry_r [MaxTargets];
  logic [7:0] rid_r [MaxTargets];
  logic [MaxTargets-1:0] rv_r;
  logic [IdxW-1:0] ptr_r;
  logic [33:0] best_r;

  // roster item decode
  logic [4:0] len_eff;
  logic store, last;
  assign len_eff = (in_list_length > 5'(MaxTargets)) ? 5'(MaxTargets) : in_list_length;
  assign store = acc && in_req_type == REQ_ENTRY && len_eff != 5'd0
                 && {1'b0, in_entry_index} < len_eff;
  assign last = {1'b0, in_entry_index} == len_eff - 5'd1;
  assign go_scan = store && last && !has_r;
  assign go_tick = acc && in_req_type == REQ_TICK && known_r && has_r;

  // distance of scanned entry
  logic signed [16:0] sdx, sdy;
  logic signed [33:0] sdx2, sdy2;
  logic [33:0] sd2;
  assign sdx = $signed({1'b0, rx_r[ptr_r]}) - $signed({1'b0, cx_r});
  assign sdy = $signed({1'b0, ry_r[ptr_r]}) - $signed({1'b0, cy_r});
  assign sdx2 = sdx * sdx;
  assign sdy2 = sdy * sdy;
  assign sd2 = unsigned'(sdx2) + unsigned'(sdy2);
  assign sts.scan_last = ptr_r == IdxW'(MaxTargets - 1);
  assign sts.eat_hit = rv_r[ptr_r] && rid_r[ptr_r] == gid_r;

  // tick calculation registers
  logic signed [16:0] dx_r, dy_r;
  logic [33:0] d2_r, rem_r;
  logic [33:0] root_r;
  logic signed [AngW-1:0] cxv_r, cyv_r, z_r;
  logic [4:0] it_r;
  logic collide_r, drive_r, eat_r;
  logic [7:0] eid_r;
  assign sts.collide = collide_r;
  assign sts.drive = drive_r;
  assign sts.calc_done = it_r == 5'(CordicSteps - 1);

  logic signed [AngW-1:0] xs, ys;
  assign xs = cxv_r >>> it_r;
  assign ys = cyv_r >>> it_r;

  logic signed [AngW-1:0] zr;
  logic signed [15:0] steer, diff, wdiff;
  logic signed [20:0] rate;
  logic [20:0] speed;
  assign zr = (z_r + 34'sd131072) >>> 18;
  assign steer = zr[15:0];
  assign diff = steer - 16'(th_r);
  assign wdiff = (diff > PiQ) ? diff - 16'(2 * PiQ)
               : (diff < -PiQ) ? diff + 16'(2 * PiQ) : diff;
  assign rate = 21'(wdiff) * $signed({17'd0, gang_r});
  assign speed = 21'(root_r) * 21'(glin_r);

  logic signed [16:0] tdx, tdy;
  logic signed [33:0] tdx2, tdy2;
  logic [33:0] td2, c2;
  assign tdx = $signed({1'b0, gx_r}) - $signed({1'b0, cx_r});
  assign tdy = $signed({1'b0, gy_r}) - $signed({1'b0, cy_r});
  assign tdx2 = tdx * tdx;
  assign tdy2 = tdy * tdy;
  assign td2 = unsigned'(tdx2) + unsigned'(tdy2);
  assign c2 = 34'(coll_r) * 34'(coll_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glin_r <= 4'd2; gang_r <= 4'd6; coll_r <= 17'd1311; srch_r <= 17'd45056;
      cx_r <= '0; cy_r <= '0; th_r <= '0; known_r <= 1'b0; has_r <= 1'b0;
      gx_r <= '0; gy_r <= '0; gid_r <= '0; rv_r <= '0; out_valid <= 1'b0;
      collide_r <= 1'b0; drive_r <= 1'b0; eat_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_GLIN: glin_r <= cfg_wdata[3:0];
          CFG_GANG: gang_r <= cfg_wdata[3:0];
          CFG_COLL: coll_r <= cfg_wdata;
          CFG_SRCH: srch_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (acc && in_req_type == REQ_POSE) begin
        cx_r <= in_pose_x; cy_r <= in_pose_y; th_r <= in_pose_theta;
        known_r <= 1'b1;
      end
      if (acc && in_req_type == REQ_ENTRY) begin
        if (len_eff == 5'd0 || in_entry_index == '0) rv_r <= '0;
        if (store) begin
          rx_r[in_entry_index] <= in_entry_x;
          ry_r[in_entry_index] <= in_entry_y;
          rid_r[in_entry_index] <= in_entry_id;
          rv_r[in_entry_index] <= 1'b1;
          if (in_entry_index == '0) rv_r <= MaxTargets'(1);
        end
      end
      if (cmd.scan_clear || cmd.eat_clear) ptr_r <= '0;
      if (cmd.scan_clear) best_r <= 34'(srch_r) * 34'(srch_r);
      if (cmd.scan_step) begin
        ptr_r <= ptr_r + 1'b1;
        if (rv_r[ptr_r] && sd2 < best_r) begin
          best_r <= sd2; gx_r <= rx_r[ptr_r]; gy_r <= ry_r[ptr_r];
          gid_r <= rid_r[ptr_r]; has_r <= 1'b1;
        end
      end
      if (cmd.tick_load) begin
        dx_r <= tdx; dy_r <= tdy; d2_r <= td2; rem_r <= td2;
        collide_r <= td2 < c2; drive_r <= td2 > c2; eat_r <= 1'b0; eid_r <= '0;
        root_r <= '0; it_r <= '0;
        if (tdx < 0) begin
          cxv_r <= -(AngW'(tdx) <<< 8); cyv_r <= -(AngW'(tdy) <<< 8);
          z_r <= (tdy >= 0) ? PiQ30 : -PiQ30;
        end else begin
          cxv_r <= AngW'(tdx) <<< 8; cyv_r <= AngW'(tdy) <<< 8; z_r <= '0;
        end
      end
      if (cmd.eat_clear) collide_r <= 1'b0;
      if (cmd.eat_step) begin
        ptr_r <= ptr_r + 1'b1;
        if (sts.eat_hit) begin
          rv_r[ptr_r] <= 1'b0; has_r <= 1'b0; eat_r <= 1'b1; eid_r <= gid_r;
        end
      end
      if (cmd.calc_step) begin
        it_r <= it_r + 1'b1;
        if (cyv_r >= 0) begin
          cxv_r <= cxv_r + ys; cyv_r <= cyv_r - xs; z_r <= z_r + atan_q30(it_r);
        end else begin
          cxv_r <= cxv_r - ys; cyv_r <= cyv_r + xs; z_r <= z_r - atan_q30(it_r);
        end
        // one root bit per step, msb first
        if (it_r >= 5'd1 && it_r <= 5'd17) begin
          logic [33:0] b2, tr;
          b2 = 34'd1 << (6'd34 - {it_r, 1'b0});
          tr = root_r + b2;
          if (rem_r >= tr) begin
            rem_r <= rem_r - tr; root_r <= (root_r >> 1) + b2;
          end else begin
            root_r <= root_r >> 1;
          end
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        out_eaten <= eat_r; out_eaten_id <= eid_r;
        if (drive_r) begin
          out_linear_speed <= (speed > 21'd1048575) ? 20'hFFFFF : speed[19:0];
          out_angular_rate <= (rate > 21'sd262143) ? 19'sh3FFFF
                            : (rate < -21'sd262144) ? -19'sd262144 : rate[18:0];
        end else begin
          out_linear_speed <= '0; out_angular_rate <= '0;
        end
      end
    end
  end

  logic unused;
  assign unused = ^{d2_r, dx_r, dy_r};

  a_eat_needs_target: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eat_step && sts.eat_hit) |-> has_r) else $error("eat without goal");
  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_eaten) |-> out_linear_speed == '0) else $error("eat with drive");
  a_tick_cond: assert property (@(posedge clk) disable iff (!rst_n)
    go_tick |-> known_r) else $error("tick without pose");
endmodule
`default_nettype wire

// ===== design/nearest_target_go_to_goal.sv =====
// top level: nearest target go-to-goal controller
// pose and roster items are registered when accepted; a roster item that completes a list
// and starts acquisition begins a roster scan (one entry per cycle)
// tick: 24 cordic steps when driving (sqrt alongside); when eating, a roster search
// a new item is not accepted while busy; results cannot be stalled
// synchronous active-low reset restores register defaults and empties the roster
`default_nettype none
module nearest_target_go_to_goal (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_req_type,
  input  wire logic [15:0]       in_pose_x,
  input  wire logic [15:0]       in_pose_y,
  input  wire logic signed [14:0] in_pose_theta,
  input  wire logic [3:0]        in_entry_index,
  input  wire logic [15:0]       in_entry_x,
  input  wire logic [15:0]       in_entry_y,
  input  wire logic [7:0]        in_entry_id,
  input  wire logic [4:0]        in_list_length,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [16:0]       cfg_wdata,
  output logic                   out_valid,
  output logic [19:0]            out_linear_speed,
  output logic signed [18:0]     out_angular_rate,
  output logic                   out_eaten,
  output logic [7:0]             out_eaten_id
);
  import ntg_pkg::*;
  ntg_cmd_t cmd;
  ntg_sts_t sts;
  logic go_scan, go_tick, acc;
  assign acc = start && !busy;

  ntg_ctrl u_ctrl (.clk, .rst_n, .go_scan, .go_tick, .sts, .cmd, .busy);
  ntg_dp u_dp (.clk, .rst_n, .acc, .in_req_type, .in_pose_x, .in_pose_y,
    .in_pose_theta, .in_entry_index, .in_entry_x, .in_entry_y, .in_entry_id,
    .in_list_length, .cfg_we, .cfg_index, .cfg_wdata, .cmd, .sts, .go_scan,
    .go_tick, .out_valid, .out_linear_speed, .out_angular_rate, .out_eaten,
    .out_eaten_id);
endmodule
`default_nettype wire
